// ----- rtl/core/ukt_pkg.sv -----
// ----------------------------------------------------------------------------
// Unique key table package
// Shared command and status codes, default sizes and the beat types of the
// request and result channels and of the token that runs along the cells.
// ----------------------------------------------------------------------------
package ukt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_BYTES_DEF = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_RENAME = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [63:0] new_key;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [5:0] index;
    logic [6:0] count;
  } result_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } token_t;

endpackage

// ----- rtl/core/ukt_cell.sv -----
// ----------------------------------------------------------------------------
// Unique key table cell
// Holds one table entry. The search token passes through once per command;
// the cell compares, records the first hit and applies insert, delete shift
// or rename to its own entry.
// ----------------------------------------------------------------------------
module ukt_cell #(
  parameter int INDEX     = 0,
  parameter int CAPACITY  = ukt_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = ukt_pkg::KEY_BYTES_DEF,
  localparam int KEY_W = 8 * KEY_BYTES,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         command,
  input  logic [KEY_W-1:0]   key,
  input  logic [KEY_W-1:0]   new_key,
  input  logic [CNT_W-1:0]   count,
  input  logic [KEY_W-1:0]   next_entry,
  input  ukt_pkg::token_t    tok_in,
  input  logic [IDX_W-1:0]   pos_in,
  output ukt_pkg::token_t    tok_out,
  output logic [IDX_W-1:0]   pos_out,
  output logic [KEY_W-1:0]   entry
);
  import ukt_pkg::*;

  logic valid_here;
  logic match;

  assign valid_here = CNT_W'(INDEX) < count;
  assign match      = valid_here && (entry == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.hit   <= tok_in.valid && (tok_in.hit || match);
    end
  end

  always_ff @(posedge clk) begin
    pos_out <= tok_in.hit ? pos_in : IDX_W'(INDEX);
    if (tok_in.valid) begin
      case (command)
        CMD_INSERT: begin
          if (!tok_in.hit && !match && CNT_W'(INDEX) == count) begin
            entry <= key;
          end
        end
        CMD_DELETE: begin
          if (valid_here && (tok_in.hit || match)) begin
            entry <= next_entry;
          end
        end
        CMD_RENAME: begin
          if (!tok_in.hit && match) begin
            entry <= new_key;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/unique_key_table.sv -----
// ----------------------------------------------------------------------------
// Unique key table
// Packed table of distinct keys with insert, delete, rename and search.
// ----------------------------------------------------------------------------
// A request beat is taken at a rising edge with start high and busy low.
// busy then stays high until the command is done. The key register feeds a
// row of CAPACITY cells; a token carrying the first-hit flag and its position
// steps one cell per cycle, and each cell updates its own entry as the token
// passes, so a delete shifts the later entries down behind the token.
// The result beat shows on result with done high for exactly one cycle,
// after the launch register, the cell row and the done register; the
// token's walk along the cell row sets how long a command lasts. busy
// falls as done rises, so the next request can be taken at the edge that
// ends the beat. The receiver has no way to stall and must take each beat.
// Reset empties the table and drops any command in flight; the entries are
// not cleared, since only entries below the count are ever compared.
// Key bytes above KEY_BYTES are ignored when comparing and storing.
// ----------------------------------------------------------------------------
module unique_key_table #(
  parameter int CAPACITY  = ukt_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = ukt_pkg::KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ukt_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output ukt_pkg::result_t  result
);
  import ukt_pkg::*;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [1:0]       command;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] new_key;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             launch;
  result_t          result_next;

  token_t           tok [CAPACITY+1];
  logic [IDX_W-1:0] pos [CAPACITY+1];
  logic [KEY_W-1:0] entry_w [CAPACITY];

  assign tok[0] = '{valid: launch, hit: 1'b0};
  assign pos[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] next_entry;
    if (i < CAPACITY - 1) begin : g_mid
      assign next_entry = entry_w[i+1];
    end else begin : g_last
      assign next_entry = '0;
    end
    ukt_cell #(
      .INDEX(i),
      .CAPACITY(CAPACITY),
      .KEY_BYTES(KEY_BYTES)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .command(command),
      .key(key),
      .new_key(new_key),
      .count(count),
      .next_entry(next_entry),
      .tok_in(tok[i]),
      .pos_in(pos[i]),
      .tok_out(tok[i+1]),
      .pos_out(pos[i+1]),
      .entry(entry_w[i])
    );
  end

  always_comb begin
    result_next = '0;
    count_next  = count;
    if (command == CMD_INSERT) begin
      if (count == CNT_W'(CAPACITY)) begin
        result_next.status = ST_FULL;
      end else if (tok[CAPACITY].hit) begin
        result_next.status = ST_DUP;
        result_next.found  = 1'b1;
        result_next.index  = 6'(32'(pos[CAPACITY]));
      end else begin
        result_next.status = ST_OK;
        result_next.index  = 6'(32'(count));
        count_next         = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      result_next.status = ST_EMPTY;
    end else if (!tok[CAPACITY].hit) begin
      result_next.status = ST_MISSING;
    end else begin
      result_next.status = ST_OK;
      result_next.found  = 1'b1;
      result_next.index  = 6'(32'(pos[CAPACITY]));
      if (command == CMD_DELETE) begin
        count_next = count - CNT_W'(1);
      end
    end
    result_next.count = 7'(32'(count_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      launch <= start && !busy;
      done   <= tok[CAPACITY].valid;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (tok[CAPACITY].valid) begin
        busy  <= 1'b0;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      command <= request.command;
      key     <= request.key[KEY_W-1:0];
      new_key <= request.new_key[KEY_W-1:0];
    end
    if (tok[CAPACITY].valid) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/core/ukt_checker.sv -----
// ----------------------------------------------------------------------------
// Unique key table checker
// Port-level properties of the command handshake and the result beats.
// ----------------------------------------------------------------------------
module ukt_checker #(
  parameter int CAPACITY = ukt_pkg::CAPACITY_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input ukt_pkg::result_t result
);
  import ukt_pkg::*;

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  a_busy_ends_with_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy fell without a result beat");

  a_result_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_MISSING) && (32'(result.count) <= CAPACITY))
    else $error("result beat out of range");

endmodule

bind unique_key_table ukt_checker #(.CAPACITY(CAPACITY)) u_ukt_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .result(result)
);
